>>> rtl/bmp_pkg.sv
// Shared types and constants for the BMP byte stream to RGB565 pixel converter.
package bmp_pkg;

   // Header layout
   localparam logic [5:0] HDR_BYTES     = 6'd54;
   localparam logic [5:0] HDR_WIDTH_LO  = 6'h12;
   localparam logic [5:0] HDR_WIDTH_HI  = 6'h13;
   localparam logic [5:0] HDR_HEIGHT_LO = 6'h16;
   localparam logic [5:0] HDR_HEIGHT_HI = 6'h17;
   localparam logic [5:0] HDR_DEPTH_LO  = 6'h1C;
   localparam logic [5:0] HDR_DEPTH_HI  = 6'h1D;

   // Supported pixel depths
   localparam logic [15:0] DEPTH_24 = 16'd24;
   localparam logic [15:0] DEPTH_16 = 16'd16;

   // Byte phase codes within one pixel
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   // Configuration register indexes and reset values
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DIMENSION = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIRROR_BASE   = 8'd1;
   localparam logic [15:0] MAX_DIMENSION_RESET = 16'd320;
   localparam logic [15:0] MIRROR_BASE_RESET   = 16'd239;

   typedef struct packed {
      logic [15:0] max_dimension;
      logic [15:0] mirror_base;
   } cfg_type;

   // Packed so that pixel_x lands in the lowest bits
   typedef struct packed {
      logic [15:0] pixel_color;
      logic [15:0] pixel_y;
      logic [15:0] pixel_x;
   } pixel_type;

endpackage

>>> rtl/bmp_stream_to_rgb565_pixels_top.sv
// Top level of the BMP byte stream to RGB565 pixel converter.
//
//   channel  direction  beat contents
//   req_     in         one file byte, file start flag in tuser
//   rsp_     out        one pixel: x, y, RGB565 color
//   csr_     in         register index and 16-bit write data
//
// One file byte is taken per clock while req_tready is high; a pixel is
// built from its last byte and leaves through the output register. The byte
// decode and scan update sit in one combinational stage between the state
// registers and the output stage. A stall on rsp_ is absorbed by a one-entry
// skid; req_tready drops only while that skid entry is full. Reset restores
// the register defaults and treats the next byte as byte 0 of a file.
module bmp_stream_to_rgb565_pixels_top
   import bmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // byte_value [7:0]
   input  logic                   req_tuser,  // file_start [0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,  // pixel_x [15:0], pixel_y [31:16],
                                              // pixel_color [47:32]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   cfg_type   cfg;
   logic      accept;
   logic      pix_valid;
   pixel_type pix;
   pixel_type out_pix;

   assign accept    = req_tvalid && req_tready;
   assign rsp_tdata = out_pix;

   bmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bmp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_tdata),
      .file_start (req_tuser),
      .cfg        (cfg),
      .pix_valid  (pix_valid),
      .pix        (pix)
   );

   bmp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pix_valid),
      .in_ready  (req_tready),
      .in_data   (pix),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_pix)
   );

endmodule

>>> rtl/bmp_csr.sv
// Configuration registers for the BMP converter.
module bmp_csr
   import bmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_DIMENSION: cfg_in.max_dimension = csr_data;
            CSR_MIRROR_BASE:   cfg_in.mirror_base   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_dimension <= MAX_DIMENSION_RESET;
         cfg_ff.mirror_base   <= MIRROR_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/bmp_core.sv
// Header capture, pixel assembly and scan position for one file byte per beat.
module bmp_core
   import bmp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic [7:0] byte_value,
   input  logic      file_start,
   input  cfg_type   cfg,
   output logic      pix_valid,
   output pixel_type pix
);

   logic [5:0]  hdr_pos_ff, hdr_pos_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;

   // Current state as seen by this beat (cleared at a file start)
   logic [5:0]  hdr_pos;
   logic [15:0] width, height, depth, held, col, row;
   logic [1:0]  phase;
   logic        emit;
   logic [15:0] color;
   logic [15:0] col_inc, row_inc;

   assign hdr_pos = file_start ? '0 : hdr_pos_ff;
   assign width   = file_start ? '0 : width_ff;
   assign height  = file_start ? '0 : height_ff;
   assign depth   = file_start ? '0 : depth_ff;
   assign held    = file_start ? '0 : held_ff;
   assign phase   = file_start ? PHASE_FIRST : phase_ff;
   assign col     = file_start ? '0 : col_ff;
   assign row     = file_start ? '0 : row_ff;

   assign col_inc = col + 16'd1;
   assign row_inc = row + 16'd1;

   // Header capture and pixel assembly
   always_comb begin
      hdr_pos_in = hdr_pos;
      width_in   = width;
      height_in  = height;
      depth_in   = depth;
      held_in    = held;
      phase_in   = phase;
      emit       = 1'b0;
      color      = '0;
      if (hdr_pos < HDR_BYTES) begin
         hdr_pos_in = hdr_pos + 6'd1;
         unique case (hdr_pos)
            HDR_WIDTH_LO:  width_in[7:0]   = byte_value;
            HDR_WIDTH_HI:  width_in[15:8]  = byte_value;
            HDR_HEIGHT_LO: height_in[7:0]  = byte_value;
            HDR_HEIGHT_HI: height_in[15:8] = byte_value;
            HDR_DEPTH_LO:  depth_in[7:0]   = byte_value;
            HDR_DEPTH_HI:  depth_in[15:8]  = byte_value;
            default: ;
         endcase
      end else if (width > cfg.max_dimension || height > cfg.max_dimension) begin
         // rejected image: consume the byte, hold the pixel state
      end else if (depth == DEPTH_24) begin
         priority if (phase == PHASE_FIRST) begin
            held_in  = {8'd0, byte_value};
            phase_in = PHASE_SECOND;
         end else if (phase == PHASE_SECOND) begin
            held_in  = {byte_value, held[7:0]};
            phase_in = PHASE_THIRD;
         end else begin
            color    = {byte_value[7:3], held[15:10], held[7:3]};
            emit     = 1'b1;
            held_in  = '0;
            phase_in = PHASE_FIRST;
         end
      end else if (depth == DEPTH_16) begin
         if (phase == PHASE_FIRST) begin
            held_in  = {8'd0, byte_value};
            phase_in = PHASE_SECOND;
         end else begin
            color    = {byte_value, held[7:0]};
            emit     = 1'b1;
            held_in  = '0;
            phase_in = PHASE_FIRST;
         end
      end
   end

   // Place the pixel and advance the scan position
   always_comb begin
      col_in = col;
      row_in = row;
      pix.pixel_color = color;
      pix.pixel_y     = row;
      if (width < height) begin
         pix.pixel_x = col;
      end else begin
         pix.pixel_x = cfg.mirror_base - col;
      end
      if (emit) begin
         if (width < height) begin
            if (col_inc >= width) begin
               col_in = '0;
               row_in = row_inc;
            end else begin
               col_in = col_inc;
            end
         end else begin
            if (row_inc >= width) begin
               row_in = '0;
               col_in = col_inc;
            end else begin
               row_in = row_inc;
            end
         end
      end
   end

   assign pix_valid = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         depth_ff   <= '0;
         held_ff    <= '0;
         phase_ff   <= PHASE_FIRST;
         col_ff     <= '0;
         row_ff     <= '0;
      end else if (accept) begin
         hdr_pos_ff <= hdr_pos_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         held_ff    <= held_in;
         phase_ff   <= phase_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

endmodule

>>> rtl/bmp_skid.sv
// Output register with a skid entry so the input ready is a registered signal.
module bmp_skid
   import bmp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output pixel_type out_data
);

   logic      main_valid_ff, main_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   pixel_type main_ff, main_in;
   pixel_type skid_ff, skid_in;
   logic      push, pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   // Refill the main entry from the skid entry first, else from the input
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
